>>> rtl/nearest_neighbor_rgb565_downscaler_core_defines.svh
// Assertion macros shared by the downscaler RTL.
`ifndef NEAREST_NEIGHBOR_RGB565_DOWNSCALER_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_RGB565_DOWNSCALER_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define NND_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("nnd: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define NND_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("nnd: next-cycle check failed");

`endif

>>> rtl/nnd_pkg.sv
package nnd_pkg;

	localparam int MAX_DIM = 1024;
	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int ACC_W   = 2 * DIM_W;
	localparam int BYTE_W  = 8;
	localparam int PIX_W   = 2 * BYTE_W;

	localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM - 1);
	localparam logic [DIM_W-1:0] RST_SRC_W = DIM_W'(96);
	localparam logic [DIM_W-1:0] RST_SRC_H = DIM_W'(95);
	localparam logic [DIM_W-1:0] RST_TGT_W = DIM_W'(32);
	localparam logic [DIM_W-1:0] RST_TGT_H = DIM_W'(32);

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_TARGET_WIDTH  = 2'd2,
		REG_TARGET_HEIGHT = 2'd3
	} cfg_reg_t;

	// effective sizes after fitting and clamping
	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] tw;
		logic [DIM_W-1:0] th;
	} dims_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [DIM_W-1:0] out_col;
		logic [DIM_W-1:0] out_row;
		logic             frame_done;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} push_t;

	typedef struct packed {
		logic phase;
		logic finished;
	} scan_status_t;

	function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_MAX)
			r = DIM_MAX;
		return r;
	endfunction

endpackage

>>> rtl/nnd_cfg.sv
module nnd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [nnd_pkg::DIM_W-1:0]  wr_data,
	output nnd_pkg::dims_t             dims
);

	logic [nnd_pkg::DIM_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [nnd_pkg::DIM_W-1:0] sw, sh, tw, th;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= nnd_pkg::RST_SRC_W;
			src_h_q <= nnd_pkg::RST_SRC_H;
			tgt_w_q <= nnd_pkg::RST_TGT_W;
			tgt_h_q <= nnd_pkg::RST_TGT_H;
		end else if (wr_en) begin
			unique case (nnd_pkg::cfg_reg_t'(wr_index))
				nnd_pkg::REG_SOURCE_WIDTH:  src_w_q <= wr_data;
				nnd_pkg::REG_SOURCE_HEIGHT: src_h_q <= wr_data;
				nnd_pkg::REG_TARGET_WIDTH:  tgt_w_q <= wr_data;
				nnd_pkg::REG_TARGET_HEIGHT: tgt_h_q <= wr_data;
			endcase
		end
	end

	// zero acts as one; target clamped to source
	always_comb begin
		sw = nnd_pkg::fit_dim(src_w_q);
		sh = nnd_pkg::fit_dim(src_h_q);
		tw = nnd_pkg::fit_dim(tgt_w_q);
		th = nnd_pkg::fit_dim(tgt_h_q);
		if (tw > sw)
			tw = sw;
		if (th > sh)
			th = sh;
		dims.sw = sw;
		dims.sh = sh;
		dims.tw = tw;
		dims.th = th;
	end

endmodule

>>> rtl/nnd_scan.sv
module nnd_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [nnd_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          frame_start,
	input  nnd_pkg::dims_t                dims,
	output nnd_pkg::push_t                push,
	output nnd_pkg::scan_status_t         status
);

	localparam int DW = nnd_pkg::DIM_W;
	localparam int AW = nnd_pkg::ACC_W;

	logic                       phase_q, finished_q;
	logic [nnd_pkg::BYTE_W-1:0] hold_q;
	logic [DW-1:0]              src_col_q, src_row_q, dst_col_q, dst_row_q;
	logic [AW-1:0]              cta_q, cpa_q, rta_q, rpa_q;

	logic                       phase_d, finished_d;
	logic [nnd_pkg::BYTE_W-1:0] hold_d;
	logic [DW-1:0]              src_col_d, src_row_d, dst_col_d, dst_row_d;
	logic [AW-1:0]              cta_d, cpa_d, rta_d, rpa_d;

	logic [AW:0]                row_lim, col_lim;
	logic                       hit, done;
	logic [DW-1:0]              dc1, dr1, sc1, sr1;

	always_comb begin
		phase_d    = phase_q;
		finished_d = finished_q;
		hold_d     = hold_q;
		src_col_d  = src_col_q;
		src_row_d  = src_row_q;
		dst_col_d  = dst_col_q;
		dst_row_d  = dst_row_q;
		cta_d      = cta_q;
		cpa_d      = cpa_q;
		rta_d      = rta_q;
		rpa_d      = rpa_q;
		done       = 1'b0;
		hit        = 1'b0;

		row_lim = {1'b0, rpa_q} + (AW + 1)'(dims.th);
		col_lim = {1'b0, cpa_q} + (AW + 1)'(dims.tw);
		dc1     = dst_col_q + DW'(1);
		dr1     = dst_row_q + DW'(1);
		sc1     = src_col_q + DW'(1);
		sr1     = src_row_q + DW'(1);

		priority if (frame_start) begin
			// restart; flagged byte is the low byte of pixel zero
			phase_d    = 1'b1;
			finished_d = 1'b0;
			hold_d     = data_byte;
			src_col_d  = '0;
			src_row_d  = '0;
			dst_col_d  = '0;
			dst_row_d  = '0;
			cta_d      = '0;
			cpa_d      = '0;
			rta_d      = '0;
			rpa_d      = '0;
		end else if (finished_q) begin
			// idle until next frame start
		end else if (!phase_q) begin
			phase_d = 1'b1;
			hold_d  = data_byte;
		end else begin
			phase_d = 1'b0;
			hit = (rpa_q <= rta_q) && ({1'b0, rta_q} < row_lim) &&
			      (cpa_q <= cta_q) && ({1'b0, cta_q} < col_lim);
			if (hit) begin
				dst_col_d = dc1;
				cta_d     = cta_q + AW'(dims.sw);
				if (dc1 >= dims.tw) begin
					dst_col_d = '0;
					cta_d     = '0;
					dst_row_d = dr1;
					rta_d     = rta_q + AW'(dims.sh);
					if (dr1 >= dims.th) begin
						done       = 1'b1;
						finished_d = 1'b1;
					end
				end
			end
			src_col_d = sc1;
			cpa_d     = cpa_q + AW'(dims.tw);
			if (sc1 >= dims.sw) begin
				src_col_d = '0;
				cpa_d     = '0;
				dst_col_d = '0;
				cta_d     = '0;
				src_row_d = sr1;
				rpa_d     = rpa_q + AW'(dims.th);
				if (sr1 >= dims.sh)
					finished_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			finished_q <= 1'b1;
			hold_q     <= '0;
			src_col_q  <= '0;
			src_row_q  <= '0;
			dst_col_q  <= '0;
			dst_row_q  <= '0;
			cta_q      <= '0;
			cpa_q      <= '0;
			rta_q      <= '0;
			rpa_q      <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			finished_q <= finished_d;
			hold_q     <= hold_d;
			src_col_q  <= src_col_d;
			src_row_q  <= src_row_d;
			dst_col_q  <= dst_col_d;
			dst_row_q  <= dst_row_d;
			cta_q      <= cta_d;
			cpa_q      <= cpa_d;
			rta_q      <= rta_d;
			rpa_q      <= rpa_d;
		end
	end

	assign push.valid          = take && hit;
	assign push.res.pixel      = {data_byte, hold_q};
	assign push.res.out_col    = dst_col_q;
	assign push.res.out_row    = dst_row_q;
	assign push.res.frame_done = done;

	assign status.phase    = phase_q;
	assign status.finished = finished_q;

endmodule

>>> rtl/nnd_outbuf.sv
module nnd_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  nnd_pkg::push_t    push,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output nnd_pkg::result_t  head
);

	logic [1:0]       cnt_q;
	nnd_pkg::result_t e0_q, e1_q;
	logic             pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign space     = (cnt_q != 2'd2);
	assign head      = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + 2'(push.valid) - 2'(pop);
	end

	// two-entry queue: e0 is the head
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push.valid && cnt_q == 2'd1)
				e0_q <= push.res;
			else
				e0_q <= e1_q;
			if (push.valid && cnt_q == 2'd2)
				e1_q <= push.res;
		end else if (push.valid) begin
			if (cnt_q == 2'd0)
				e0_q <= push.res;
			else
				e1_q <= push.res;
		end
	end

endmodule

>>> rtl/nearest_neighbor_rgb565_downscaler_core.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     data_byte, frame_start
// output    out_valid / out_ready   pixel, out_col, out_row, frame_done
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; a pixel is queued in a register on its high byte.
// Byte state and selection update in one pass at the input request.
// A two-entry output queue lets input continue while a pixel waits; in_ready
// drops only when both entries are held. cfg_ready is always high.
// Reset: default sizes 96x95 -> 32x32, no output until a frame start byte.
`include "nearest_neighbor_rgb565_downscaler_core_defines.svh"

module nearest_neighbor_rgb565_downscaler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [nnd_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nnd_pkg::PIX_W-1:0]     pixel,
	output logic [nnd_pkg::DIM_W-1:0]     out_col,
	output logic [nnd_pkg::DIM_W-1:0]     out_row,
	output logic                          frame_done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [nnd_pkg::DIM_W-1:0]     cfg_data
);

	nnd_pkg::dims_t        dims;
	nnd_pkg::push_t        push;
	nnd_pkg::scan_status_t status;
	nnd_pkg::result_t      head;
	logic                  space;
	logic                  take;

	// size registers are always writable
	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign take      = in_valid && in_ready;

	nnd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.dims     (dims)
	);

	// byte pairing, source/target accumulators and the pick
	nnd_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.dims        (dims),
		.push        (push),
		.status      (status)
	);

	nnd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign pixel      = head.pixel;
	assign out_col    = head.out_col;
	assign out_row    = head.out_row;
	assign frame_done = head.frame_done;

	// a pixel is only produced on the high byte of an active frame
	`NND_ASSERT_NOW(a_push_high_byte, clk, arst_n, push.valid, status.phase && !frame_start && !status.finished)
	// nothing comes out between frames
	`NND_ASSERT_NOW(a_idle_quiet, clk, arst_n, take && status.finished && !frame_start, !push.valid)
	// last pixel of a frame parks the scanner
	`NND_ASSERT_NEXT(a_done_parks, clk, arst_n, push.valid && push.res.frame_done, status.finished)

endmodule

>>> tb/tb_nearest_neighbor_rgb565_downscaler_core.sv
`timescale 1ns / 100ps

module tb_nearest_neighbor_rgb565_downscaler_core;

	localparam int BYTE_W = nnd_pkg::BYTE_W;
	localparam int PIX_W  = nnd_pkg::PIX_W;
	localparam int DIM_W  = nnd_pkg::DIM_W;
	localparam int ACC_W  = nnd_pkg::ACC_W;

	localparam int SETTLE_CYCLES = 6;     // lets a pixel drain through the 2-deep queue
	localparam int QUIET_LIMIT   = 2000;  // longest legal quiet spell is the receiver hold-off
	localparam int RANDOM_BYTES  = 250;
	localparam int LARGE_BYTES   = 300;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    data_byte   = '0;
	logic                 frame_start = 1'b0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [PIX_W-1:0]     pixel;
	logic [DIM_W-1:0]     out_col;
	logic [DIM_W-1:0]     out_row;
	logic                 frame_done;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index   = '0;
	logic [DIM_W-1:0]     cfg_data    = '0;

	nearest_neighbor_rgb565_downscaler_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel       (pixel),
		.out_col     (out_col),
		.out_row     (out_row),
		.frame_done  (frame_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Scaler model: its own copy of the size registers and scan counters
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] size_src_w, size_src_h, size_tgt_w, size_tgt_h;

	bit               high_half;      // next byte completes a pixel
	bit [BYTE_W-1:0]  low_keep;
	bit [DIM_W-1:0]   col_in, row_in;   // source position
	bit [DIM_W-1:0]   col_out, row_out; // next output position
	bit [ACC_W-1:0]   col_want;       // col_out * width of source
	bit [ACC_W-1:0]   col_have;       // col_in  * width of target
	bit [ACC_W-1:0]   row_want;       // row_out * height of source
	bit [ACC_W-1:0]   row_have;       // row_in  * height of target
	bit               scan_idle;      // ignoring bytes until a frame start

	nnd_pkg::result_t selected_pixels[$];

	int bytes_taken, bytes_used, pixels_checked, frames_closed, reg_writes, mismatches;
	bit idling;
	int hold_request;
	int quiet_cycles;

	function automatic int unsigned fitted(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > nnd_pkg::DIM_MAX)
			return 32'(nnd_pkg::DIM_MAX);
		return 32'(v);
	endfunction

	function automatic int source_frame_bytes();
		return int'(2 * fitted(size_src_w) * fitted(size_src_h));
	endfunction

	function automatic void restart_scan();
		high_half = 1'b0;
		low_keep  = '0;
		col_in    = '0;
		row_in    = '0;
		col_out   = '0;
		row_out   = '0;
		col_want  = '0;
		col_have  = '0;
		row_want  = '0;
		row_have  = '0;
	endfunction

	// One accepted byte: updates the scan and queues the pixel it selects, if any
	function automatic void advance_scan(input logic [BYTE_W-1:0] b, input logic fs);
		int unsigned      sw, sh, tw, th;
		nnd_pkg::result_t r;
		if (fs) begin
			restart_scan();
			scan_idle = 1'b0;
		end
		if (scan_idle)
			return;
		bytes_used++;
		if (!high_half) begin
			low_keep  = b;
			high_half = 1'b1;
			return;
		end
		high_half = 1'b0;

		sw = fitted(size_src_w);
		sh = fitted(size_src_h);
		tw = fitted(size_tgt_w);
		th = fitted(size_tgt_h);
		if (tw > sw)
			tw = sw;
		if (th > sh)
			th = sh;

		// source (c,r) is picked when c*TW <= dx*SW < (c+1)*TW, same for rows
		if (row_have <= row_want && row_want < row_have + th &&
		    col_have <= col_want && col_want < col_have + tw) begin
			r.pixel      = {b, low_keep};
			r.out_col    = col_out;
			r.out_row    = row_out;
			r.frame_done = 1'b0;
			col_out  = col_out + 1'b1;
			col_want = ACC_W'(col_want + sw);
			if (col_out >= tw) begin
				col_out  = '0;
				col_want = '0;
				row_out  = row_out + 1'b1;
				row_want = ACC_W'(row_want + sh);
				if (row_out >= th) begin
					r.frame_done = 1'b1;
					scan_idle    = 1'b1;
				end
			end
			selected_pixels.push_back(r);
		end

		col_in   = col_in + 1'b1;
		col_have = ACC_W'(col_have + tw);
		if (col_in >= sw) begin
			col_in   = '0;
			col_have = '0;
			col_out  = '0;
			col_want = '0;
			row_in   = row_in + 1'b1;
			row_have = ACC_W'(row_have + th);
			// source exhausted before the last output row: stop quietly
			if (row_in >= sh)
				scan_idle = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Pacing, driving and checking
	// ------------------------------------------------------------------
	// mostly back to back, some short gaps, the odd long one
	function automatic int pick_gap();
		int r;
		if (!idling)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 60)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(4, 20));
	endfunction

	function automatic logic [DIM_W-1:0] pick_size(input int hi);
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 5)
			return '0;
		if (r < 90)
			return DIM_W'($urandom_range(1, hi));
		return DIM_W'($urandom_range(hi + 1, 3 * hi + 4));
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
	                               input int unsigned want);
		$display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// Keeps in_valid high into the next request when there is no gap, so the
	// valid never sees a low and a high in the same step.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		bytes_taken++;
		advance_scan(b, fs);
	endtask

	task automatic send_frame(input int n);
		for (int k = 0; k < n; k++)
			send_byte(BYTE_W'($urandom_range(0, 255)), k == 0);
	endtask

	// Block is idle once every expected pixel is out and the pipe has settled
	task automatic wait_for_pixels();
		in_valid <= 1'b0;
		while (selected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four size registers back to back; only call when idle
	task automatic apply_sizes(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
	                           input logic [DIM_W-1:0] tw, input logic [DIM_W-1:0] th);
		logic [DIM_W-1:0]  vals [4];
		nnd_pkg::cfg_reg_t idx;
		vals = '{sw, sh, tw, th};
		idx  = nnd_pkg::REG_SOURCE_WIDTH;
		repeat (4) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[idx];
			do @(posedge clk); while (!cfg_ready);
			unique case (idx)
				nnd_pkg::REG_SOURCE_WIDTH:  size_src_w = vals[idx];
				nnd_pkg::REG_SOURCE_HEIGHT: size_src_h = vals[idx];
				nnd_pkg::REG_TARGET_WIDTH:  size_tgt_w = vals[idx];
				nnd_pkg::REG_TARGET_HEIGHT: size_tgt_h = vals[idx];
			endcase
			reg_writes++;
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
	endtask

	// Receiver pacing: random stalls, or a long hold-off on request
	initial begin : receiver_pacing
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n != 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Every pixel request is matched against the oldest expected one
	always @(posedge clk) begin : pixel_check
		nnd_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (selected_pixels.size() == 0) begin
				report_mismatch("unexpected pixel", 32'(pixel), 0);
			end else begin
				want = selected_pixels.pop_front();
				if (pixel !== want.pixel)
					report_mismatch("pixel", 32'(pixel), 32'(want.pixel));
				if (out_col !== want.out_col)
					report_mismatch("out_col", 32'(out_col), 32'(want.out_col));
				if (out_row !== want.out_row)
					report_mismatch("out_row", 32'(out_row), 32'(want.out_row));
				if (frame_done !== want.frame_done)
					report_mismatch("frame_done", 32'(frame_done), 32'(want.frame_done));
				pixels_checked++;
			end
			if (frame_done === 1'b1)
				frames_closed++;
		end
	end

	// Watchdog: too long without any request moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no request moved for %0d cycles, %0d pixels outstanding",
			         $time, QUIET_LIMIT, selected_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset sizes 96x95 -> 32x32: bytes before a frame start are dropped, then
	// the first three source rows give output rows 0 and 1.
	task automatic test_reset_sizes();
		idling = 1'b1;
		repeat (4) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		send_frame(3 * 96 * 2);
	endtask

	task automatic test_directed_cases();
		idling = 1'b1;
		wait_for_pixels();
		apply_sizes(DIM_W'(2), DIM_W'(2), DIM_W'(2), DIM_W'(2));
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);   // last pixel, frame done
		send_byte(8'h12, 1'b0);   // after the frame: ignored
		send_byte(8'h34, 1'b0);
		send_byte(8'h11, 1'b1);
		send_byte(8'h22, 1'b1);   // restart mid-pixel, 0x22 becomes the low byte
		send_byte(8'h33, 1'b0);
		send_byte(8'h44, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h66, 1'b1);   // restart mid-frame on a pixel boundary
		send_byte(8'h77, 1'b0);
		// zero in every size register acts as one: single-pixel frame
		wait_for_pixels();
		apply_sizes('0, '0, '0, '0);
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b0);
		// target larger than source gets clamped
		wait_for_pixels();
		apply_sizes(DIM_W'(3), DIM_W'(2), nnd_pkg::DIM_MAX, nnd_pkg::DIM_MAX);
		send_frame(source_frame_bytes());
	endtask

	// Widest row and tallest column the registers can hold; only the opening
	// stretch of each frame is sent
	task automatic test_largest_sizes();
		idling = 1'b0;
		wait_for_pixels();
		apply_sizes(nnd_pkg::DIM_MAX, '0, nnd_pkg::DIM_MAX, DIM_W'(5));
		send_frame(LARGE_BYTES);
		wait_for_pixels();
		idling = 1'b1;
		apply_sizes('0, nnd_pkg::DIM_MAX, DIM_W'(2), nnd_pkg::DIM_MAX);
		send_frame(LARGE_BYTES);
	endtask

	// Receiver holds off while every source pixel is wanted, so the output
	// queue fills and in_ready has to drop
	task automatic test_output_hold();
		wait_for_pixels();
		apply_sizes(DIM_W'(8), DIM_W'(4), DIM_W'(8), DIM_W'(4));
		idling = 1'b0;
		hold_request = 300;
		send_frame(source_frame_bytes());
		wait_for_pixels();
	endtask

	// Sizes change part way through a frame; the scan carries on with the
	// new ones and may run out of source rows before the last output row
	task automatic test_resize_mid_frame();
		logic [DIM_W-1:0] sw, sh;
		idling = 1'b1;
		repeat (4) begin
			wait_for_pixels();
			sw = pick_size(8);
			sh = pick_size(6);
			apply_sizes(sw, sh, DIM_W'($urandom_range(0, fitted(sw) + 2)),
			            DIM_W'($urandom_range(0, fitted(sh) + 2)));
			send_frame(int'($urandom_range(1, source_frame_bytes())));
			wait_for_pixels();
			sw = pick_size(8);
			sh = pick_size(6);
			apply_sizes(sw, sh, DIM_W'($urandom_range(0, fitted(sw) + 2)),
			            DIM_W'($urandom_range(0, fitted(sh) + 2)));
			repeat ($urandom_range(1, 80)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// Mostly whole frames of random pixels at random small sizes; the rest
	// are cut-short frames, stray bytes around frames and random frame starts
	task automatic test_random_streams();
		int               used_at_start, kind;
		logic [DIM_W-1:0] sw, sh;
		used_at_start = bytes_used;
		while (bytes_used - used_at_start < RANDOM_BYTES) begin
			wait_for_pixels();
			sw = pick_size(12);
			sh = pick_size(6);
			apply_sizes(sw, sh, DIM_W'($urandom_range(0, fitted(sw) + 2)),
			            DIM_W'($urandom_range(0, fitted(sh) + 2)));
			idling = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3)) begin
				kind = int'($urandom_range(0, 9));
				if (kind < 7) begin
					send_frame(source_frame_bytes());
				end else if (kind == 7) begin
					send_frame(int'($urandom_range(1, source_frame_bytes())));
				end else if (kind == 8) begin
					repeat ($urandom_range(1, 6))
						send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
					send_frame(source_frame_bytes() + int'($urandom_range(1, 6)));
				end else begin
					repeat ($urandom_range(8, 40))
						send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
				end
			end
		end
	endtask

	initial begin
		size_src_w = nnd_pkg::RST_SRC_W;
		size_src_h = nnd_pkg::RST_SRC_H;
		size_tgt_w = nnd_pkg::RST_TGT_W;
		size_tgt_h = nnd_pkg::RST_TGT_H;
		restart_scan();
		scan_idle = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_directed_cases();
		test_largest_sizes();
		test_output_hold();
		test_resize_mid_frame();
		test_random_streams();
		wait_for_pixels();

		$display("Run covered %0d bytes (%0d inside frames), %0d register writes,",
		         bytes_taken, bytes_used, reg_writes);
		$display("and %0d pixels checked over %0d finished frames; %0d mismatches.",
		         pixels_checked, frames_closed, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
